>>> rtl/csvp_pkg.sv
`default_nettype none

package csvp_pkg;

    localparam int ROW_OUT_BITS   = 16;
    localparam int FIELD_OUT_BITS = 20;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [1:0] {
        MODE_OUT   = 2'd0,
        MODE_IN    = 2'd1,
        MODE_QSEEN = 2'd2
    } quote_mode_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_FEND = 2'd1,
        KIND_REND = 2'd2,
        KIND_SUM  = 2'd3
    } out_kind_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_OPEN   = 3'd1,
        ST_QEND   = 3'd2,
        ST_NOROWS = 3'd3,
        ST_UNEVEN = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_DIV  = 2'd1,
        SEQ_SUM  = 2'd2
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

>>> rtl/csvp_div.sv
`default_nettype none

module csvp_div
    import csvp_pkg::*;
#(
    parameter int DVD_BITS = 20,
    parameter int DVS_BITS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [DVD_BITS-1:0] dividend,
    input  wire logic [DVS_BITS-1:0] divisor,
    output div_status_t              div_status,
    output logic      [DVD_BITS-1:0] quotient,
    output logic      [DVS_BITS-1:0] remainder
);

    localparam int CNT_W = $clog2(DVD_BITS);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DVD_BITS-1:0] quo_reg, quo_next;
    logic [DVS_BITS-1:0] rem_reg, rem_next;
    logic [DVS_BITS-1:0] dvs_reg, dvs_next;
    logic [DVS_BITS:0]   trial;
    logic [DVS_BITS:0]   diff;
    logic                fits;

    assign trial = {rem_reg, quo_reg[DVD_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_BITS - 1);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DVD_BITS-2:0], fits};
            rem_next = fits ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign div_status.busy = busy_reg;
    assign div_status.done = done_reg;
    assign quotient        = quo_reg;
    assign remainder       = rem_reg;

endmodule

`default_nettype wire

>>> rtl/csv_quoted_field_parser.sv
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_ready  action, byte_value
// out      output     out_valid/out_ready out_kind, out_byte, status,
//                                        row_count, field_count, column_count
//
// A data byte is accepted whenever in_ready is high; in_ready needs the
// sequencer idle and the output register empty or being drained. An end-of-file
// item with no quote error and at least one row runs the restoring divider,
// one quotient bit a cycle; the summary loads once it is done and out is free.
// rst_n clears the quote mode, counters and handshake state.
`default_nettype none

module csv_quoted_field_parser
    import csvp_pkg::*;
#(
    parameter int ROW_COUNT_BITS   = 16,
    parameter int FIELD_COUNT_BITS = 20
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      action,
    input  wire logic [7:0]                byte_value,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [1:0]                     out_kind,
    output logic [7:0]                     out_byte,
    output logic [2:0]                     status,
    output logic [ROW_OUT_BITS-1:0]        row_count,
    output logic [FIELD_OUT_BITS-1:0]      field_count,
    output logic [FIELD_OUT_BITS-1:0]      column_count
);

    localparam logic [ROW_COUNT_BITS-1:0]   ROW_MAX   = '1;
    localparam logic [FIELD_COUNT_BITS-1:0] FIELD_MAX = '1;

    seq_state_t                  state_reg, state_next;
    quote_mode_t                 mode_reg, mode_next;
    logic [ROW_COUNT_BITS-1:0]   rows_reg, rows_next;
    logic [FIELD_COUNT_BITS-1:0] fields_reg, fields_next;
    logic                        out_valid_reg, out_valid_next;
    out_kind_t                   kind_reg, kind_next;
    logic [7:0]                  byte_reg, byte_next;
    status_t                     status_reg, status_next;
    logic [ROW_OUT_BITS-1:0]     rc_reg, rc_next;
    logic [FIELD_OUT_BITS-1:0]   fc_reg, fc_next;
    logic [FIELD_OUT_BITS-1:0]   cc_reg, cc_next;

    logic                        slot_free;
    logic                        accept;
    logic                        out_load;
    logic                        do_outside;
    logic                        add_field;
    logic                        add_row;
    logic                        div_start;
    div_status_t                 div_status;
    logic [FIELD_COUNT_BITS-1:0] div_quo;
    logic [ROW_COUNT_BITS-1:0]   div_rem;

    csvp_div #(
        .DVD_BITS (FIELD_COUNT_BITS),
        .DVS_BITS (ROW_COUNT_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (div_start),
        .dividend   (fields_reg),
        .divisor    (rows_reg),
        .div_status (div_status),
        .quotient   (div_quo),
        .remainder  (div_rem)
    );

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == SEQ_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        rows_next   = rows_reg;
        fields_next = fields_reg;
        out_load    = 1'b0;
        kind_next   = KIND_DATA;
        byte_next   = '0;
        status_next = ST_OK;
        rc_next     = '0;
        fc_next     = '0;
        cc_next     = '0;
        do_outside  = 1'b0;
        add_field   = 1'b0;
        add_row     = 1'b0;
        div_start   = 1'b0;

        case (state_reg)
            SEQ_IDLE:
            begin
                if (accept && action)
                begin
                    rc_next = ROW_OUT_BITS'(rows_reg);
                    fc_next = FIELD_OUT_BITS'(fields_reg);
                    kind_next = KIND_SUM;
                    if (mode_reg == MODE_IN || mode_reg == MODE_QSEEN
                        || rows_reg == '0)
                    begin
                        out_load = 1'b1;
                        if (mode_reg == MODE_IN)
                            status_next = ST_OPEN;
                        else if (mode_reg == MODE_QSEEN)
                            status_next = ST_QEND;
                        else
                            status_next = ST_NOROWS;
                        mode_next   = MODE_OUT;
                        rows_next   = '0;
                        fields_next = '0;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = SEQ_DIV;
                    end
                end
                else if (accept)
                begin
                    case (mode_reg)
                        MODE_IN:
                        begin
                            if (byte_value == CH_QUOTE)
                                mode_next = MODE_QSEEN;
                            else
                            begin
                                out_load  = 1'b1;
                                byte_next = byte_value;
                            end
                        end
                        MODE_QSEEN:
                        begin
                            if (byte_value == CH_QUOTE)
                            begin
                                mode_next = MODE_IN;
                                out_load  = 1'b1;
                                byte_next = CH_QUOTE;
                            end
                            else
                                do_outside = 1'b1;
                        end
                        default:
                            do_outside = 1'b1;
                    endcase

                    if (do_outside)
                    begin
                        mode_next = MODE_OUT;
                        case (byte_value)
                            CH_QUOTE: mode_next = MODE_IN;
                            CH_COMMA:
                            begin
                                add_field = 1'b1;
                                out_load  = 1'b1;
                                kind_next = KIND_FEND;
                            end
                            CH_CR: ;
                            CH_LF:
                            begin
                                add_field = 1'b1;
                                add_row   = 1'b1;
                                out_load  = 1'b1;
                                kind_next = KIND_REND;
                            end
                            default:
                            begin
                                out_load  = 1'b1;
                                byte_next = byte_value;
                            end
                        endcase
                    end

                    if (add_field && fields_reg != FIELD_MAX)
                        fields_next = fields_reg + 1'b1;
                    if (add_row && rows_reg != ROW_MAX)
                        rows_next = rows_reg + 1'b1;
                end
            end
            SEQ_DIV:
            begin
                if (div_status.done)
                    state_next = SEQ_SUM;
            end
            SEQ_SUM:
            begin
                if (slot_free)
                begin
                    out_load  = 1'b1;
                    kind_next = KIND_SUM;
                    rc_next   = ROW_OUT_BITS'(rows_reg);
                    fc_next   = FIELD_OUT_BITS'(fields_reg);
                    if (div_rem != '0)
                        status_next = ST_UNEVEN;
                    else
                        cc_next = FIELD_OUT_BITS'(div_quo);
                    mode_next   = MODE_OUT;
                    rows_next   = '0;
                    fields_next = '0;
                    state_next  = SEQ_IDLE;
                end
            end
            default:
                state_next = SEQ_IDLE;
        endcase

        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            mode_reg      <= MODE_OUT;
            rows_reg      <= '0;
            fields_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            rows_reg      <= rows_next;
            fields_reg    <= fields_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            kind_reg   <= kind_next;
            byte_reg   <= byte_next;
            status_reg <= status_next;
            rc_reg     <= rc_next;
            fc_reg     <= fc_next;
            cc_reg     <= cc_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_kind     = kind_reg;
    assign out_byte     = byte_reg;
    assign status       = status_reg;
    assign row_count    = rc_reg;
    assign field_count  = fc_reg;
    assign column_count = cc_reg;

    a_no_accept_while_dividing: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> !in_ready)
        else $error("input accepted while divider busy");

    a_div_only_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> state_reg == SEQ_DIV)
        else $error("divider running outside divide state");

    a_error_summary_no_columns: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_SUM && status_reg != ST_OK)
            |-> cc_reg == '0)
        else $error("error summary carries a column count");

    a_summary_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && kind_next == KIND_SUM)
            |=> rows_reg == '0 && fields_reg == '0 && mode_reg == MODE_OUT)
        else $error("state not cleared after summary");

endmodule

`default_nettype wire
